// ----- rtl/core/sdpfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdpfa_pkg
// Shared types, codes and helpers of the soft disk pair force accumulator.
// ----------------------------------------------------------------------------
package sdpfa_pkg;

  localparam int MaxDisksDefault = 1024;

  // request opcodes
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_PAIR = 2'd1;
  localparam op_t OP_READ = 2'd2;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOX_W     = 3'd0;
  localparam cfg_idx_t CFG_BOX_H     = 3'd1;
  localparam cfg_idx_t CFG_BOX_W_INV = 3'd2;
  localparam cfg_idx_t CFG_BOX_H_INV = 3'd3;
  localparam cfg_idx_t CFG_SPRING    = 3'd4;

  localparam logic [31:0] SpringReset = 32'd65536;
  localparam logic [47:0] ForceMax    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] ForceMin    = 48'h8000_0000_0000;
  localparam logic [48:0] DeltaLimit  = 49'h1_0000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_OUT, S_RDJ, S_DIFF, S_MX, S_MY, S_SX, S_SY, S_SQX, S_SQY,
    S_SUM, S_SQRT, S_CHK, S_KY, S_NXL, S_NXH, S_NYL, S_NYH, S_NYA, S_DSET,
    S_DIV, S_FRI, S_FRJ, S_FWJ
  } state_e;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r;
  } disk_t;

  typedef struct packed {
    logic        mark;
    logic [47:0] fy;
    logic [47:0] fx;
  } force_t;

  typedef struct packed {
    logic [47:0] val;
    logic        sat;
  } sat_res_t;

  // Saturating add of a signed magnitude delta to a 48-bit accumulator.
  function automatic sat_res_t sat_acc(input logic [47:0] acc, input logic [48:0] mag,
                                       input logic neg);
    logic signed [50:0] a;
    logic signed [50:0] b;
    logic signed [50:0] s;
    sat_res_t res;
    a = 51'($signed(acc));
    b = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    s = a + b;
    res.sat = 1'b0;
    res.val = s[47:0];
    if (s > 51'($signed(ForceMax))) begin
      res.val = ForceMax;
      res.sat = 1'b1;
    end else if (s < 51'($signed(ForceMin))) begin
      res.val = ForceMin;
      res.sat = 1'b1;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/soft_disk_pair_force_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// soft_disk_pair_force_accumulator
// Disk store with per-disk saturating harmonic repulsion force sums.
// ----------------------------------------------------------------------------
// A load request writes both memories on acceptance. A read request passes
// through the read-out state, which loads the output register, and holds the
// input meanwhile. A pair request occupies the block for a 32-step square root
// and a 48-step divide (both force components in parallel, one quotient bit
// per cycle), which dominate, plus memory reads, shared 33x33 multiplier steps
// and the two read-modify-write passes on the force memory; a pair that does
// not overlap frees the block after the overlap check. Disk state and force
// sums live in two single-port-read, single-port-write memories with registered
// read data. A pending read result sits in an output register, so loads and
// pairs are taken while it waits, a read not until it is taken. The memories
// have no reset; a disk must be loaded before a pair or read request names it.
module soft_disk_pair_force_accumulator
  import sdpfa_pkg::*;
#(
  parameter int MAX_DISKS = MaxDisksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [9:0]  index_i_i,
  input  wire logic [9:0]  index_j_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] radius_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [9:0]       disk_index_o,
  output logic [47:0]      force_x_o,
  output logic [47:0]      force_y_o,
  output logic             saturated_o
);

  localparam int AW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;

  // configuration
  logic [31:0] box_w_q, box_h_q, box_w_inv_q, box_h_inv_q, spring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_w_q     <= '0;
      box_h_q     <= '0;
      box_w_inv_q <= '0;
      box_h_inv_q <= '0;
      spring_q    <= SpringReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_W:     box_w_q     <= cfg_data_i;
        CFG_BOX_H:     box_h_q     <= cfg_data_i;
        CFG_BOX_W_INV: box_w_inv_q <= cfg_data_i;
        CFG_BOX_H_INV: box_h_inv_q <= cfg_data_i;
        CFG_SPRING:    spring_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request handshake and index checks
  state_e state_q, state_d;
  logic   in_fire, i_ok, j_ok;

  assign i_ok    = 32'(index_i_i) < MAX_DISKS;
  assign j_ok    = 32'(index_j_i) < MAX_DISKS;
  assign in_fire = in_valid_i && in_ready_o;

  logic out_valid_q;
  // Take a request while idle; hold a read only while its result slot is busy.
  assign in_ready_o = (state_q == S_IDLE) &&
                      (!out_valid_q || out_ready_i || (op_i != OP_READ));

  // memories
  disk_t  disk_mem [MAX_DISKS];
  force_t force_mem[MAX_DISKS];

  logic [AW-1:0] d_raddr, d_waddr, f_raddr, f_waddr;
  logic          d_we, f_we;
  disk_t         d_wdata, drd_q;
  force_t        f_wdata, frd_q;

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      disk_mem[d_waddr] <= d_wdata;
    end
    drd_q <= disk_mem[d_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      force_mem[f_waddr] <= f_wdata;
    end
    frd_q <= force_mem[f_raddr];
  end

  // datapath registers
  logic [9:0]  i_q, j_q;
  logic        rd_ok_q;
  logic [31:0] xi_q, yi_q, ri_q;
  logic [32:0] mag_x_q, mag_y_q, dsum_q, dd_q;
  logic        neg_x_q, neg_y_q, sgn_x_q, sgn_y_q;
  logic [31:0] fm_x_q, fm_y_q, sm_x_q, sm_y_q;
  logic [63:0] sq_q, res_q, one_q, ksx_q, ksy_q;
  logic [95:0] numx_q, numy_q;
  logic [47:0] den_q, remx_q, remy_q, shx_q, shy_q, qx_q, qy_q;
  logic        clampx_q, clampy_q;
  logic [5:0]  cnt_q;
  logic [65:0] prod_q;
  logic [32:0] mul_a, mul_b;

  // shared multiplier, registered product
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // combinational helpers
  logic [32:0] dx, dy;
  logic [48:0] r2x, r2y;
  logic [31:0] fb, fm;
  logic [63:0] rnd, root_try;
  logic [31:0] d_val;
  logic [48:0] qfx, qfy;
  sat_res_t    sx_i, sy_i, sx_j, sy_j;

  assign dx       = {xi_q[31], xi_q} - {drd_q.x[31], drd_q.x};
  assign dy       = {yi_q[31], yi_q} - {drd_q.y[31], drd_q.y};
  assign fb       = prod_q[47:16];
  // Round to nearest image: a fraction of one half or more wraps to its complement.
  assign fm       = fb[31] ? 32'(33'h1_0000_0000 - {1'b0, fb}) : fb;
  assign rnd      = prod_q[63:0] + 64'h8000_0000;
  assign root_try = res_q + one_q;
  assign d_val    = res_q[31:0];
  assign r2x      = {remx_q, shx_q[47]};
  assign r2y      = {remy_q, shy_q[47]};
  assign qfx      = clampx_q ? DeltaLimit : {1'b0, qx_q};
  assign qfy      = clampy_q ? DeltaLimit : {1'b0, qy_q};
  assign sx_i     = sat_acc(frd_q.fx, qfx, sgn_x_q);
  assign sy_i     = sat_acc(frd_q.fy, qfy, sgn_y_q);
  assign sx_j     = sat_acc(frd_q.fx, qfx, !sgn_x_q);
  assign sy_j     = sat_acc(frd_q.fy, qfy, !sgn_y_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_i == OP_READ) begin
            state_d = S_RD_OUT;
          end else if (op_i == OP_PAIR && i_ok && j_ok) begin
            state_d = S_RDJ;
          end
        end
      end
      S_RD_OUT: state_d = S_IDLE;
      S_RDJ:    state_d = S_DIFF;
      S_DIFF:   state_d = S_MX;
      S_MX:     state_d = S_MY;
      S_MY:     state_d = S_SX;
      S_SX:     state_d = S_SY;
      S_SY:     state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_SUM;
      S_SUM:    state_d = S_SQRT;
      S_SQRT:   state_d = (cnt_q == '0) ? S_CHK : S_SQRT;
      S_CHK: begin
        // drop coincident or non-overlapping pairs
        if (d_val == '0 || {1'b0, d_val} >= dsum_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_KY;
        end
      end
      S_KY:     state_d = S_NXL;
      S_NXL:    state_d = S_NXH;
      S_NXH:    state_d = S_NYL;
      S_NYL:    state_d = S_NYH;
      S_NYH:    state_d = S_NYA;
      S_NYA:    state_d = S_DSET;
      S_DSET:   state_d = S_DIV;
      S_DIV:    state_d = (cnt_q == '0) ? S_FRI : S_DIV;
      S_FRI:    state_d = S_FRJ;
      S_FRJ:    state_d = S_FWJ;
      S_FWJ:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // memory ports and multiplier operands
  always_comb begin
    d_raddr = AW'(index_i_i);
    d_waddr = AW'(index_i_i);
    d_we    = 1'b0;
    d_wdata = '{x: pos_x_i, y: pos_y_i, r: radius_i};
    f_raddr = AW'(index_i_i);
    f_waddr = AW'(index_i_i);
    f_we    = 1'b0;
    f_wdata = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && op_i == OP_LOAD && i_ok) begin
          d_we = 1'b1;
          f_we = 1'b1;
        end
      end
      S_RDJ: d_raddr = AW'(j_q);
      S_MX: begin
        mul_a = mag_x_q;
        mul_b = {1'b0, box_w_inv_q};
      end
      S_MY: begin
        mul_a = mag_y_q;
        mul_b = {1'b0, box_h_inv_q};
      end
      S_SX: begin
        mul_a = {1'b0, fm_x_q};
        mul_b = {1'b0, box_w_q};
      end
      S_SY: begin
        mul_a = {1'b0, fm_y_q};
        mul_b = {1'b0, box_h_q};
      end
      S_SQX: begin
        mul_a = {1'b0, sm_x_q};
        mul_b = {1'b0, sm_x_q};
      end
      S_SQY: begin
        mul_a = {1'b0, sm_y_q};
        mul_b = {1'b0, sm_y_q};
      end
      S_CHK: begin
        mul_a = {1'b0, spring_q};
        mul_b = {1'b0, sm_x_q};
      end
      S_KY: begin
        mul_a = {1'b0, spring_q};
        mul_b = {1'b0, sm_y_q};
      end
      S_NXL: begin
        mul_a = {1'b0, ksx_q[31:0]};
        mul_b = dd_q;
      end
      S_NXH: begin
        mul_a = {1'b0, ksx_q[63:32]};
        mul_b = dd_q;
      end
      S_NYL: begin
        mul_a = {1'b0, ksy_q[31:0]};
        mul_b = dd_q;
      end
      S_NYH: begin
        mul_a = {1'b0, ksy_q[63:32]};
        mul_b = dd_q;
      end
      S_FRI: f_raddr = AW'(i_q);
      S_FRJ: begin
        // write back disk i while disk j is read
        f_raddr = AW'(j_q);
        f_waddr = AW'(i_q);
        f_we    = 1'b1;
        f_wdata = '{mark: frd_q.mark | sx_i.sat | sy_i.sat, fy: sy_i.val, fx: sx_i.val};
      end
      S_FWJ: begin
        f_waddr = AW'(j_q);
        f_we    = 1'b1;
        f_wdata = '{mark: frd_q.mark | sx_j.sat | sy_j.sat, fy: sy_j.val, fx: sx_j.val};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          i_q     <= index_i_i;
          j_q     <= index_j_i;
          rd_ok_q <= i_ok;
        end
      end
      S_RDJ: begin
        xi_q <= drd_q.x;
        yi_q <= drd_q.y;
        ri_q <= drd_q.r;
      end
      S_DIFF: begin
        neg_x_q <= dx[32];
        neg_y_q <= dy[32];
        mag_x_q <= dx[32] ? (~dx + 33'd1) : dx;
        mag_y_q <= dy[32] ? (~dy + 33'd1) : dy;
        dsum_q  <= {1'b0, ri_q} + {1'b0, drd_q.r};
      end
      S_MY: begin
        fm_x_q  <= fm;
        sgn_x_q <= neg_x_q ^ fb[31];
      end
      S_SX: begin
        fm_y_q  <= fm;
        sgn_y_q <= neg_y_q ^ fb[31];
      end
      S_SY:  sm_x_q <= rnd[63:32];
      S_SQX: sm_y_q <= rnd[63:32];
      S_SQY: sq_q   <= prod_q[63:0];
      S_SUM: begin
        sq_q  <= sq_q + prod_q[63:0];
        res_q <= '0;
        one_q <= 64'h4000_0000_0000_0000;
        cnt_q <= 6'd31;
      end
      S_SQRT: begin
        // one result bit per step
        if (sq_q >= root_try) begin
          sq_q  <= sq_q - root_try;
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
        cnt_q <= cnt_q - 6'd1;
      end
      S_CHK: dd_q <= dsum_q - {1'b0, d_val};
      S_KY:  ksx_q <= prod_q[63:0];
      S_NXL: ksy_q <= prod_q[63:0];
      S_NXH: numx_q <= 96'(prod_q[64:0]);
      S_NYL: numx_q <= numx_q + {prod_q[63:0], 32'd0};
      S_NYH: numy_q <= 96'(prod_q[64:0]);
      S_NYA: numy_q <= numy_q + {prod_q[63:0], 32'd0};
      S_DSET: begin
        // a quotient at or above the limit shows up in the top half alone
        den_q    <= {d_val, 16'd0};
        clampx_q <= numx_q[95:48] >= {d_val, 16'd0};
        clampy_q <= numy_q[95:48] >= {d_val, 16'd0};
        remx_q   <= numx_q[95:48];
        remy_q   <= numy_q[95:48];
        shx_q    <= numx_q[47:0];
        shy_q    <= numy_q[47:0];
        qx_q     <= '0;
        qy_q     <= '0;
        cnt_q    <= 6'd47;
      end
      S_DIV: begin
        if (r2x >= {1'b0, den_q}) begin
          remx_q <= 48'(r2x - {1'b0, den_q});
          qx_q   <= {qx_q[46:0], 1'b1};
        end else begin
          remx_q <= r2x[47:0];
          qx_q   <= {qx_q[46:0], 1'b0};
        end
        if (r2y >= {1'b0, den_q}) begin
          remy_q <= 48'(r2y - {1'b0, den_q});
          qy_q   <= {qy_q[46:0], 1'b1};
        end else begin
          remy_q <= r2y[47:0];
          qy_q   <= {qy_q[46:0], 1'b0};
        end
        shx_q <= shx_q << 1;
        shy_q <= shy_q << 1;
        cnt_q <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

  // result register
  logic [9:0]  disk_index_q;
  logic [47:0] fx_out_q, fy_out_q;
  logic        sat_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_OUT) begin
      disk_index_q <= i_q;
      fx_out_q     <= rd_ok_q ? frd_q.fx : '0;
      fy_out_q     <= rd_ok_q ? frd_q.fy : '0;
      sat_out_q    <= rd_ok_q ? frd_q.mark : 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign disk_index_o = disk_index_q;
  assign force_x_o    = fx_out_q;
  assign force_y_o    = fy_out_q;
  assign saturated_o  = sat_out_q;

`ifndef ASSERT_OFF
  // a read result must never land on a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_OUT) |-> !out_valid_q)
    else $error("read result overwrites a pending result");

  // the force memory is written only by a load or the two write-back steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_we |-> (state_q == S_IDLE || state_q == S_FRJ || state_q == S_FWJ))
    else $error("stray force memory write");

  // disk j write-back ends the pair and frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWJ) |=> (state_q == S_IDLE))
    else $error("pair sequence did not return to idle");
`endif

endmodule
`default_nettype wire

// ----- tb/soft_disk_pair_force_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_disk_pair_force_accumulator_test
// Drives load, pair and read requests into the disk force accumulator under
// several box and stiffness settings and flow-control mixes. A local force
// predictor tracks every disk and checks each read result field by field.
// ----------------------------------------------------------------------------
module soft_disk_pair_force_accumulator_test;
  import sdpfa_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;  // reserved opcode, dropped by the block
  localparam int  DISKS     = 1024;
  localparam int  POOL      = 16;
  localparam int  DRAIN     = 150;   // covers a pair request still in flight
  localparam int  WD_LIMIT  = 5000;  // cycles with no handshake on either side and no config write
  localparam logic [31:0] BOX64     = 32'd64 << 16;
  localparam logic [31:0] BOX64_INV = 32'd1 << 26;

  typedef struct {
    logic [9:0]  idx;
    logic [47:0] fx;
    logic [47:0] fy;
    logic        sat;
  } force_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [9:0]  index_i_i = '0;
  logic [9:0]  index_j_i = '0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] radius_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  disk_index_o;
  logic [47:0] force_x_o;
  logic [47:0] force_y_o;
  logic        saturated_o;

  soft_disk_pair_force_accumulator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the block: registers, disk store and force sums.
  logic [31:0]        box_w, box_h, inv_w, inv_h, stiffness;
  logic signed [31:0] disk_x [DISKS];
  logic signed [31:0] disk_y [DISKS];
  logic [31:0]        disk_r [DISKS];
  logic [47:0]        sum_x  [DISKS];
  logic [47:0]        sum_y  [DISKS];
  bit                 sat_mark [DISKS];
  logic [9:0]         pool [POOL];

  force_report_t pending_reports[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  int  quiet_cycles = 0;

  // Minimum-image separation on one axis, signed Q16.16.
  function automatic longint signed wrap_axis(longint signed a, longint signed b,
                                              logic [31:0] inv, logic [31:0] box);
    longint signed dx;
    logic [63:0] mag, prod, frac, fmag, smag;
    bit neg, fneg;
    dx   = a - b;
    neg  = dx < 0;
    mag  = neg ? 64'(-dx) : 64'(dx);
    prod = (mag * 64'(inv)) >> 16;
    frac = {32'd0, prod[31:0]};
    fneg = frac[31];
    fmag = fneg ? (64'h1_0000_0000 - frac) : frac;
    smag = (fmag * 64'(box) + 64'h8000_0000) >> 32;
    return (neg != fneg) ? -longint'(smag) : longint'(smag);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v   = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  // One force component, Q32.16, magnitude clamped to 2^48.
  function automatic longint signed spring_push(logic [63:0] overlap, longint signed s,
                                                logic [63:0] span);
    logic [127:0] num, q;
    logic [63:0]  smag;
    smag = (s < 0) ? 64'(-s) : 64'(s);
    num  = 128'(stiffness) * 128'(smag) * 128'(overlap);
    q    = num / (128'(span) << 16);
    if (q > (128'd1 << 48)) q = 128'd1 << 48;
    return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [47:0] clamp_add(logic [47:0] acc, longint signed delta,
                                            inout bit mark);
    longint signed s;
    s = longint'($signed(acc)) + delta;
    if (s > 64'sh7FFF_FFFF_FFFF) begin
      s = 64'sh7FFF_FFFF_FFFF;
      mark = 1'b1;
    end
    if (s < -64'sh8000_0000_0000) begin
      s = -64'sh8000_0000_0000;
      mark = 1'b1;
    end
    return s[47:0];
  endfunction

  // Advance the predictor by one accepted request.
  task automatic apply_request(op_t op, logic [9:0] i, logic [9:0] j, logic [31:0] x,
                               logic [31:0] y, logic [31:0] r);
    longint signed sx, sy, fx, fy;
    logic [63:0] ax, ay, span, reach;
    force_report_t rep;
    case (op)
      OP_LOAD: begin
        disk_x[i] = x; disk_y[i] = y; disk_r[i] = r;
        sum_x[i] = '0; sum_y[i] = '0; sat_mark[i] = 1'b0;
      end
      OP_PAIR: begin
        sx = wrap_axis(longint'(disk_x[i]), longint'(disk_x[j]), inv_w, box_w);
        sy = wrap_axis(longint'(disk_y[i]), longint'(disk_y[j]), inv_h, box_h);
        ax = (sx < 0) ? 64'(-sx) : 64'(sx);
        ay = (sy < 0) ? 64'(-sy) : 64'(sy);
        span  = floor_root(ax * ax + ay * ay);
        reach = 64'(disk_r[i]) + 64'(disk_r[j]);
        if (span != 0 && span < reach) begin
          fx = spring_push(reach - span, sx, span);
          fy = spring_push(reach - span, sy, span);
          sum_x[i] = clamp_add(sum_x[i], fx, sat_mark[i]);
          sum_y[i] = clamp_add(sum_y[i], fy, sat_mark[i]);
          sum_x[j] = clamp_add(sum_x[j], -fx, sat_mark[j]);
          sum_y[j] = clamp_add(sum_y[j], -fy, sat_mark[j]);
        end
      end
      OP_READ: begin
        rep.idx = i; rep.fx = sum_x[i]; rep.fy = sum_y[i]; rep.sat = sat_mark[i];
        pending_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  // Offer one request; valid stays high on return so back-to-back requests flow.
  task automatic send_request(op_t op, logic [9:0] i, logic [9:0] j, logic [31:0] x,
                              logic [31:0] y, logic [31:0] r);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; index_i_i <= i; index_j_i <= j;
    pos_x_i <= x; pos_y_i <= y; radius_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(op, i, j, x, y, r);
  endtask

  // Drain outstanding work, then write all five registers.
  task automatic set_config(logic [31:0] bw, logic [31:0] bh, logic [31:0] iw,
                            logic [31:0] ih, logic [31:0] k);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BOX_W;     cfg_data_i <= bw; @(posedge clk_i);
    cfg_idx_i <= CFG_BOX_H;     cfg_data_i <= bh; @(posedge clk_i);
    cfg_idx_i <= CFG_BOX_W_INV; cfg_data_i <= iw; @(posedge clk_i);
    cfg_idx_i <= CFG_BOX_H_INV; cfg_data_i <= ih; @(posedge clk_i);
    cfg_idx_i <= CFG_SPRING;    cfg_data_i <= k;  @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_w = bw; box_h = bh; inv_w = iw; inv_h = ih; stiffness = k;
  endtask

  function automatic logic [31:0] pick_pos();
    if ($urandom_range(99) < 15) return $urandom;
    return $urandom_range(0, BOX64 - 1);
  endfunction

  function automatic logic [31:0] pick_radius();
    if ($urandom_range(99) < 10) return $urandom;
    return $urandom_range(32'd1 << 15, 32'd8 << 16);
  endfunction

  // Load a fresh pool of disks at random indexes, then mix requests on it.
  task automatic run_random_phase(int count);
    int n, pick, slot;
    for (n = 0; n < POOL; n++) begin
      pool[n] = 10'($urandom);
      send_request(OP_LOAD, pool[n], 10'($urandom), pick_pos(), pick_pos(), pick_radius());
    end
    n = POOL;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // reload a pool slot, sometimes moving it to a fresh index first
        slot = $urandom_range(POOL - 1);
        if ($urandom_range(3) == 0) pool[slot] = 10'($urandom);
        send_request(OP_LOAD, pool[slot], 10'($urandom),
                     pick_pos(), pick_pos(), pick_radius());
        n++;
      end else if (pick < 68) begin
        send_request(OP_PAIR, pool[$urandom_range(POOL - 1)], pool[$urandom_range(POOL - 1)],
                     $urandom, $urandom, $urandom);
        n++;
      end else if (pick < 96) begin
        send_request(OP_READ, pool[$urandom_range(POOL - 1)], 10'($urandom),
                     $urandom, $urandom, $urandom);
        n++;
      end else begin
        send_request(OP_UNUSED, 10'($urandom), 10'($urandom), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Default registers: box of zero, so no pair adds force; index and field extremes.
  task automatic test_reset_defaults();
    send_request(OP_LOAD, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 10'd1023, 10'd1023, 32'h0, 32'h0, 32'h0);
    send_request(OP_PAIR, 10'd0, 10'd1023, '0, '0, '0);
    send_request(OP_PAIR, 10'd1023, 10'd1023, '0, '0, '0);
    send_request(OP_UNUSED, 10'd1023, 10'd0, '1, '1, '1);
    send_request(OP_READ, 10'd0, 10'd0, '0, '0, '0);
    send_request(OP_READ, 10'd1023, 10'd0, '0, '0, '0);
  endtask

  // Box of 64: overlapping, wrapped across the edge, coincident and self pairs.
  task automatic test_pair_geometry();
    set_config(BOX64, BOX64, BOX64_INV, BOX64_INV, SpringReset);
    send_request(OP_LOAD, 10'd5, 10'd0, 32'd10 << 16, 32'd10 << 16, 32'd2 << 16);
    send_request(OP_LOAD, 10'd6, 10'd0, 32'd11 << 16, 32'd12 << 16, 32'd2 << 16);
    send_request(OP_LOAD, 10'd7, 10'd0, 32'd63 << 16, 32'd10 << 16, 32'd3 << 16);
    send_request(OP_LOAD, 10'd8, 10'd0, 32'd10 << 16, 32'd10 << 16, 32'd1 << 16);
    send_request(OP_PAIR, 10'd5, 10'd6, '0, '0, '0);
    send_request(OP_PAIR, 10'd7, 10'd5, '0, '0, '0);
    send_request(OP_PAIR, 10'd5, 10'd8, '0, '0, '0);
    send_request(OP_PAIR, 10'd6, 10'd6, '0, '0, '0);
    send_request(OP_READ, 10'd5, 10'd0, '0, '0, '0);
    send_request(OP_READ, 10'd6, 10'd0, '0, '0, '0);
    send_request(OP_READ, 10'd7, 10'd0, '0, '0, '0);
  endtask

  // Maximum stiffness and radii drive the sums into saturation; a reload clears it.
  task automatic test_saturation();
    set_config(BOX64, BOX64, BOX64_INV, BOX64_INV, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 10'd100, 10'd0, 32'd20 << 16, 32'd20 << 16, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 10'd101, 10'd0, 32'd21 << 16, 32'd20 << 16, 32'hFFFF_FFFF);
    repeat (3) send_request(OP_PAIR, 10'd100, 10'd101, '0, '0, '0);
    send_request(OP_READ, 10'd100, 10'd0, '0, '0, '0);
    send_request(OP_READ, 10'd101, 10'd0, '0, '0, '0);
    send_request(OP_LOAD, 10'd100, 10'd0, 32'd20 << 16, 32'd20 << 16, 32'd1);
    send_request(OP_READ, 10'd100, 10'd0, '0, '0, '0);
  endtask

  task automatic test_random_no_idle();
    set_config(BOX64, BOX64, BOX64_INV, BOX64_INV, SpringReset);
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random_phase(125);
  endtask

  task automatic test_random_sender_idle();
    set_config(32'd6553600, 32'd6553600, 32'd42949673, 32'd42949673, $urandom);
    send_idle_pct = 45; recv_stall_pct = 0;
    run_random_phase(125);
  endtask

  task automatic test_random_receiver_stall();
    set_config($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    send_idle_pct = 0; recv_stall_pct = 45;
    run_random_phase(125);
  endtask

  // Hold off the receiver long enough that the read result backs up into the input.
  task automatic test_output_backpressure();
    int n;
    set_config(BOX64, 32'hFFFF_FFFF, BOX64_INV, 32'd1, $urandom_range(0, 32'd4 << 16));
    send_idle_pct = 32; recv_stall_pct = 32;
    pool[0] = 10'd512;
    send_request(OP_LOAD, 10'd512, 10'd0, 32'd1 << 16, 32'd1 << 16, 32'd1 << 16);
    hold_cycles = 400;
    for (n = 0; n < 20; n++) send_request(OP_READ, 10'd512, 10'd0, '0, '0, '0);
    run_random_phase(125);
  endtask

  // Receiver: random stalls per phase, plus the long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result against the oldest expected report.
  always @(posedge clk_i) begin
    force_report_t exp_rep;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result for disk %0d", disk_index_o);
        errors++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (disk_index_o !== exp_rep.idx) begin
          $error("disk_index: expected %0d, got %0d", exp_rep.idx, disk_index_o);
          errors++;
        end
        if (force_x_o !== exp_rep.fx) begin
          $error("force_x: expected %h, got %h", exp_rep.fx, force_x_o);
          errors++;
        end
        if (force_y_o !== exp_rep.fy) begin
          $error("force_y: expected %h, got %h", exp_rep.fy, force_y_o);
          errors++;
        end
        if (saturated_o !== exp_rep.sat) begin
          $error("saturated: expected %b, got %b", exp_rep.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    box_w = '0; box_h = '0; inv_w = '0; inv_h = '0; stiffness = SpringReset;
    for (int n = 0; n < DISKS; n++) begin
      disk_x[n] = '0; disk_y[n] = '0; disk_r[n] = '0;
      sum_x[n] = '0; sum_y[n] = '0; sat_mark[n] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_pair_geometry();
    test_saturation();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sdpfa_pkg.sv
rtl/core/soft_disk_pair_force_accumulator.sv
tb/soft_disk_pair_force_accumulator_test.sv
